/* rtl/core/efb_pkg.sv */
// Shared types and constants for the escaped frame builder.
// Depends on nothing; used by escaped_frame_builder_top.
`default_nettype none
package efb_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] function_code;
        logic [9:0]  payload_len;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
    } t_out_req;

    localparam logic [7:0]  FLAG_BYTE  = 8'hE7;
    localparam logic [7:0]  ESC_BYTE   = 8'hE6;
    localparam logic [7:0]  ESC_FLAG   = 8'h02;
    localparam logic [7:0]  ESC_ESC    = 8'h01;
    localparam logic [7:0]  ID_PREFIX  = 8'h49;
    localparam logic [15:0] HEADER_LEN = 16'd16;

    localparam logic [0:0] CFG_DEV_SERIAL = 1'd0;
    localparam logic [0:0] CFG_ESC_EN     = 1'd1;

endpackage
`default_nettype wire

/* rtl/core/escaped_frame_builder_top.sv */
// Escaped frame builder: framing, header, XOR check and byte stuffing.
// Depends on efb_pkg (request types and framing constants).
//
//   channel | dir | handshake                  | payload
//   in      | in  | i_in_valid / o_in_ready    | i_in  (efb_pkg::t_in_req)
//   out     | out | o_out_valid / i_out_ready  | o_out (efb_pkg::t_out_req)
//   cfg     | in  | i_cfg_wr_en                | i_cfg_idx, i_cfg_wdata
//
// One output byte per cycle from a step sequencer while the output is not stalled;
// an item costs one cycle per emitted byte, and an escaped byte emits an escape pair.
// The next request is taken in the cycle its predecessor's final byte is loaded.
// A stray payload request with no frame open is taken and dropped.
// Output register stalls hold the sequencer; reset is synchronous, active low.
`default_nettype none
module escaped_frame_builder_top #(
    parameter int MAX_PAYLOAD = 1008
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  efb_pkg::t_in_req   i_in,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output efb_pkg::t_out_req  o_out,
    input  wire                i_cfg_wr_en,
    input  wire  [0:0]         i_cfg_idx,
    input  wire  [47:0]        i_cfg_wdata
);

    localparam logic [4:0] ST_FLAG   = 5'd0;
    localparam logic [4:0] ST_FC_HI  = 5'd1;
    localparam logic [4:0] ST_FC_LO  = 5'd2;
    localparam logic [4:0] ST_LEN_HI = 5'd3;
    localparam logic [4:0] ST_LEN_LO = 5'd4;
    localparam logic [4:0] ST_ID     = 5'd5;
    localparam logic [4:0] ST_DS5    = 5'd6;
    localparam logic [4:0] ST_DS4    = 5'd7;
    localparam logic [4:0] ST_DS3    = 5'd8;
    localparam logic [4:0] ST_DS2    = 5'd9;
    localparam logic [4:0] ST_DS1    = 5'd10;
    localparam logic [4:0] ST_DS0    = 5'd11;
    localparam logic [4:0] ST_MS_HI  = 5'd12;
    localparam logic [4:0] ST_MS_LO  = 5'd13;
    localparam logic [4:0] ST_DATA   = 5'd14;
    localparam logic [4:0] ST_CHECK  = 5'd15;
    localparam logic [4:0] ST_EOF    = 5'd16;

    logic [47:0] r_dev_serial;
    logic        r_esc_en;
    logic [15:0] r_msg_serial;
    logic [7:0]  r_chk;
    logic        r_open;

    logic        r_busy;
    logic [4:0]  r_step;
    logic        r_esc_pend;
    logic        r_kind;
    logic [15:0] r_fc;
    logic [15:0] r_len;
    logic [7:0]  r_data;
    logic        r_last;

    logic        r_oval;
    logic [7:0]  r_obyte;
    logic        r_oeof;

    logic        load;
    logic        accept;
    logic        finish;
    logic        need_esc;
    logic        stuffable;
    logic        checked;
    logic [7:0]  cur_byte;
    logic [7:0]  n_obyte;
    logic [4:0]  n_step;
    logic        opens;
    logic [15:0] sat_len;

    always_comb begin
        case (r_step)
            ST_FLAG:   cur_byte = efb_pkg::FLAG_BYTE;
            ST_FC_HI:  cur_byte = r_fc[15:8];
            ST_FC_LO:  cur_byte = r_fc[7:0];
            ST_LEN_HI: cur_byte = r_len[15:8];
            ST_LEN_LO: cur_byte = r_len[7:0];
            ST_ID:     cur_byte = efb_pkg::ID_PREFIX;
            ST_DS5:    cur_byte = r_dev_serial[47:40];
            ST_DS4:    cur_byte = r_dev_serial[39:32];
            ST_DS3:    cur_byte = r_dev_serial[31:24];
            ST_DS2:    cur_byte = r_dev_serial[23:16];
            ST_DS1:    cur_byte = r_dev_serial[15:8];
            ST_DS0:    cur_byte = r_dev_serial[7:0];
            ST_MS_HI:  cur_byte = r_msg_serial[15:8];
            ST_MS_LO:  cur_byte = r_msg_serial[7:0];
            ST_DATA:   cur_byte = r_data;
            ST_CHECK:  cur_byte = r_chk;
            ST_EOF:    cur_byte = efb_pkg::FLAG_BYTE;
            default:   cur_byte = efb_pkg::FLAG_BYTE;
        endcase
    end

    always_comb begin
        case (r_step)
            ST_MS_LO: n_step = r_kind ? ST_CHECK : ST_DATA;
            ST_DATA:  n_step = ST_CHECK;
            ST_CHECK: n_step = ST_EOF;
            default:  n_step = r_step + 5'd1;
        endcase
    end

    assign stuffable = (r_step != ST_FLAG) && (r_step != ST_EOF);
    assign checked   = stuffable && (r_step != ST_CHECK);
    assign need_esc  = r_esc_en && stuffable &&
                       ((cur_byte == efb_pkg::FLAG_BYTE) || (cur_byte == efb_pkg::ESC_BYTE));

    always_comb begin
        if (r_esc_pend) begin
            n_obyte = (cur_byte == efb_pkg::FLAG_BYTE) ? efb_pkg::ESC_FLAG : efb_pkg::ESC_ESC;
        end else if (need_esc) begin
            n_obyte = efb_pkg::ESC_BYTE;
        end else begin
            n_obyte = cur_byte;
        end
    end

    assign load   = r_busy && (!r_oval || i_out_ready);
    assign finish = load && !(need_esc && !r_esc_pend) &&
                    ((r_step == ST_EOF) || ((r_step == ST_DATA) && !r_last));
    assign o_in_ready = !r_busy || finish;
    assign accept = i_in_valid && o_in_ready;
    assign opens  = i_in.kind || i_in.first_byte;
    assign sat_len = (32'(i_in.payload_len) > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD)
                                                          : 16'(i_in.payload_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_serial <= '0;
            r_esc_en     <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                efb_pkg::CFG_DEV_SERIAL: r_dev_serial <= i_cfg_wdata;
                efb_pkg::CFG_ESC_EN:     r_esc_en     <= i_cfg_wdata[0];
                default:                 r_esc_en     <= r_esc_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_step       <= ST_FLAG;
            r_esc_pend   <= 1'b0;
            r_open       <= 1'b0;
            r_msg_serial <= '0;
            r_chk        <= '0;
            r_oval       <= 1'b0;
        end else begin
            if (load) begin
                r_oval <= 1'b1;
                if (r_step == ST_FLAG) begin
                    r_chk <= '0;
                end else if (checked && !r_esc_pend) begin
                    r_chk <= r_chk ^ cur_byte;
                end
                if (r_step == ST_EOF) begin
                    r_chk        <= '0;
                    r_msg_serial <= r_msg_serial + 16'd1;
                end
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end

            if (accept && (opens || r_open)) begin
                r_busy     <= 1'b1;
                r_esc_pend <= 1'b0;
                r_step     <= opens ? ST_FLAG : ST_DATA;
            end else begin
                if (load) begin
                    if (need_esc && !r_esc_pend) begin
                        r_esc_pend <= 1'b1;
                    end else begin
                        r_esc_pend <= 1'b0;
                        r_step     <= n_step;
                    end
                end
                if (finish) begin
                    r_busy <= 1'b0;
                end
            end

            if (accept) begin
                if (i_in.kind) begin
                    r_open <= 1'b0;
                end else if (opens || r_open) begin
                    r_open <= !i_in.last_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_in.kind;
            r_fc   <= i_in.function_code;
            r_len  <= efb_pkg::HEADER_LEN + (i_in.kind ? 16'd0 : sat_len);
            r_data <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
        if (load) begin
            r_obyte <= n_obyte;
            r_oeof  <= (r_step == ST_EOF);
        end
    end

    assign o_out_valid        = r_oval;
    assign o_out.out_byte     = r_obyte;
    assign o_out.end_of_frame = r_oeof;

    a_eof_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.end_of_frame) |-> (o_out.out_byte == efb_pkg::FLAG_BYTE))
        else $error("end of frame on a non-flag byte");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_pend |-> (r_busy && r_step != ST_FLAG && r_step != ST_EOF))
        else $error("escape pending outside a stuffable byte");

    a_serial_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_step == ST_EOF) |=> (r_msg_serial == $past(r_msg_serial) + 16'd1))
        else $error("message serial did not advance on close");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !finish) |-> !o_in_ready)
        else $error("request taken while an item is in flight");

endmodule
`default_nettype wire
